// ===== rtl/u8tl_pkg.sv =====
// Package for the UTF-8 Turkish lowercase converter.
// Beat types for both stream channels and the byte codes used by the case mapping.
// No dependencies.
package u8tl_pkg;

    localparam int unsigned CAP_W     = 16;
    localparam int unsigned MAX_RES   = 5;
    localparam int unsigned RES_CNT_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd4096;

    localparam logic [7:0] ASCII_CAP_A   = 8'h41;
    localparam logic [7:0] ASCII_CAP_Z   = 8'h5A;
    localparam logic [7:0] ASCII_CAP_I   = 8'h49;
    localparam logic [7:0] ASCII_SMALL_I = 8'h69;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    localparam logic [7:0] LEAD_C3 = 8'hC3;
    localparam logic [7:0] LEAD_C4 = 8'hC4;
    localparam logic [7:0] LEAD_C5 = 8'hC5;
    localparam logic [7:0] CONT_B0 = 8'hB0;
    localparam logic [7:0] CONT_B1 = 8'hB1;
    localparam logic [7:0] CONT_87 = 8'h87;
    localparam logic [7:0] CONT_A7 = 8'hA7;
    localparam logic [7:0] CONT_9E = 8'h9E;
    localparam logic [7:0] CONT_9F = 8'h9F;
    localparam logic [7:0] CONT_96 = 8'h96;
    localparam logic [7:0] CONT_B6 = 8'hB6;
    localparam logic [7:0] CONT_9C = 8'h9C;
    localparam logic [7:0] CONT_BC = 8'hBC;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
        logic       truncated;
    } out_beat_t;

endpackage

// ===== rtl/utf8_turkish_lowercase.sv =====
// UTF-8 Turkish lowercase converter, top level.
// Result beats are registered: the first one is offered in the cycle after the input beat is accepted.
// Throughput: one input beat per cycle while each byte gives at most one result and dst_ready is high;
// a byte giving k results (k up to 5) holds the input until the output buffer drains.
// Reset: pending character, stop flag and output buffer cleared, capacity 4096.
// Depends on u8tl_pkg.
module utf8_turkish_lowercase (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       src_valid,
    output logic                       src_ready,
    input  u8tl_pkg::in_beat_t         src_data,
    output logic                       dst_valid,
    input  logic                       dst_ready,
    output u8tl_pkg::out_beat_t        dst_data,
    input  logic                       cfg_we,
    input  logic [u8tl_pkg::CAP_W-1:0] cfg_data
);

    import u8tl_pkg::*;

    function automatic logic [CAP_W-1:0] budget_of(input logic [CAP_W-1:0] cap);
        budget_of = (cap == '0) ? '0 : cap - 1'b1;
    endfunction

    // character state
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [CAP_W-1:0] space_reg, space_next;
    logic [7:0]       pend_reg [3];
    logic [7:0]       pend_next [3];
    logic [1:0]       pc_reg, pc_next;
    logic [2:0]       el_reg, el_next;
    logic             stop_reg, stop_next;

    // result buffer
    logic [7:0]           buf_byte_reg [MAX_RES];
    logic [RES_CNT_W-1:0] buf_cnt_reg, buf_cnt_next;
    logic [RES_CNT_W-1:0] buf_rd_reg, buf_rd_next;
    logic                 buf_marker_reg, buf_marker_next;
    logic                 buf_last_reg, buf_last_next;
    logic                 buf_trunc_reg, buf_trunc_next;

    logic       accept, out_fire, at_end;
    logic [7:0] cur_b;
    logic       ends, is_cont, cont_path, do_flush_old, do_fresh, complete;

    // fresh byte decode
    logic [1:0] fresh_len;
    logic [7:0] fresh_b [2];
    logic       fresh_lead;
    logic [2:0] fresh_el;

    // completed character
    logic [2:0] comp_len;
    logic [7:0] comp_b [4];

    // candidate output bytes
    logic [7:0]           slot_byte [MAX_RES];
    logic [RES_CNT_W-1:0] slot_end [MAX_RES];
    logic [RES_CNT_W-1:0] total, base, emit_cnt, res_cnt;
    logic                 over, marker;

    assign accept   = src_valid && src_ready;
    assign out_fire = dst_valid && dst_ready;
    assign cur_b    = src_data.in_byte;
    assign ends     = src_data.in_last || (cur_b == 8'h00);
    assign is_cont  = (cur_b[7:6] == 2'b10);

    assign cont_path    = (pc_reg != 2'd0) && (cur_b != 8'h00) && is_cont;
    assign do_flush_old = (pc_reg != 2'd0) && ((cur_b == 8'h00) || !is_cont);
    assign do_fresh     = (cur_b != 8'h00) && !cont_path;
    assign complete     = ({1'b0, pc_reg} + 3'd1) >= el_reg;

    always_comb
    begin
        fresh_b[0] = cur_b;
        fresh_b[1] = 8'h00;
        fresh_len  = 2'd1;
        fresh_lead = 1'b0;
        fresh_el   = 3'd0;
        if (!cur_b[7])
        begin
            if (cur_b == ASCII_CAP_I)
            begin
                fresh_b[0] = LEAD_C4;
                fresh_b[1] = CONT_B1;
                fresh_len  = 2'd2;
            end
            else if (cur_b >= ASCII_CAP_A && cur_b <= ASCII_CAP_Z)
            begin
                fresh_b[0] = cur_b + CASE_OFFSET;
            end
        end
        else if (cur_b[7:5] == 3'b110)
        begin
            fresh_lead = 1'b1;
            fresh_len  = 2'd0;
            fresh_el   = 3'd2;
        end
        else if (cur_b[7:4] == 4'hE)
        begin
            fresh_lead = 1'b1;
            fresh_len  = 2'd0;
            fresh_el   = 3'd3;
        end
        else if (cur_b[7:3] == 5'b11110)
        begin
            fresh_lead = 1'b1;
            fresh_len  = 2'd0;
            fresh_el   = 3'd4;
        end
    end

    // completed character: the Turkish two-byte capitals are mapped, the rest pass through
    always_comb
    begin
        comp_b[0] = pend_reg[0];
        comp_b[1] = pend_reg[1];
        comp_b[2] = pend_reg[2];
        comp_b[3] = 8'h00;
        comp_len  = {1'b0, pc_reg} + 3'd1;
        case (pc_reg)
            2'd1:
            begin
                comp_b[1] = cur_b;
                if (pend_reg[0] == LEAD_C4 && cur_b == CONT_B0)
                begin
                    comp_b[0] = ASCII_SMALL_I;
                    comp_len  = 3'd1;
                end
                else if (pend_reg[0] == LEAD_C3 && cur_b == CONT_87)
                    comp_b[1] = CONT_A7;
                else if (pend_reg[0] == LEAD_C4 && cur_b == CONT_9E)
                    comp_b[1] = CONT_9F;
                else if (pend_reg[0] == LEAD_C3 && cur_b == CONT_96)
                    comp_b[1] = CONT_B6;
                else if (pend_reg[0] == LEAD_C5 && cur_b == CONT_9E)
                    comp_b[1] = CONT_9F;
                else if (pend_reg[0] == LEAD_C3 && cur_b == CONT_9C)
                    comp_b[1] = CONT_BC;
            end
            2'd2:    comp_b[2] = cur_b;
            2'd3:    comp_b[3] = cur_b;
            default: ;
        endcase
    end

    // ordered list of output bytes; slot_end is the running count at the end of its character
    always_comb
    begin
        for (int k = 0; k < MAX_RES; k++)
        begin
            slot_byte[k] = 8'h00;
            slot_end[k]  = '0;
        end
        total = '0;
        base  = '0;
        if (!stop_reg)
        begin
            if (do_flush_old)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (2'(i) < pc_reg)
                    begin
                        slot_byte[total] = pend_reg[i];
                        slot_end[total]  = total + 3'd1;
                        total            = total + 3'd1;
                    end
                end
            end
            if (do_fresh)
            begin
                base = total;
                for (int j = 0; j < 2; j++)
                begin
                    if (2'(j) < fresh_len)
                    begin
                        slot_byte[total] = fresh_b[j];
                        slot_end[total]  = base + {1'b0, fresh_len};
                        total            = total + 3'd1;
                    end
                end
                if (fresh_lead && ends)
                begin
                    slot_byte[total] = cur_b;
                    slot_end[total]  = total + 3'd1;
                    total            = total + 3'd1;
                end
            end
            if (cont_path)
            begin
                if (complete)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        if (3'(j) < comp_len)
                        begin
                            slot_byte[total] = comp_b[j];
                            slot_end[total]  = comp_len;
                            total            = total + 3'd1;
                        end
                    end
                end
                else if (ends)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (2'(i) < pc_reg)
                        begin
                            slot_byte[total] = pend_reg[i];
                            slot_end[total]  = total + 3'd1;
                            total            = total + 3'd1;
                        end
                    end
                    slot_byte[total] = cur_b;
                    slot_end[total]  = total + 3'd1;
                    total            = total + 3'd1;
                end
            end
        end
    end

    // budget: a byte goes out when its whole character fits
    always_comb
    begin
        emit_cnt = '0;
        for (int k = 0; k < MAX_RES; k++)
        begin
            if ((RES_CNT_W'(k) < total) &&
                ({{(CAP_W-RES_CNT_W){1'b0}}, slot_end[k]} <= space_reg))
                emit_cnt = emit_cnt + 3'd1;
        end
        over    = {{(CAP_W-RES_CNT_W){1'b0}}, total} > space_reg;
        marker  = ends && (emit_cnt == '0);
        res_cnt = marker ? 3'd1 : emit_cnt;
    end

    always_comb
    begin
        cap_next   = cap_reg;
        space_next = space_reg;
        pend_next  = pend_reg;
        pc_next    = pc_reg;
        el_next    = el_reg;
        stop_next  = stop_reg;
        if (accept)
        begin
            if (ends)
            begin
                pend_next[0] = 8'h00;
                pend_next[1] = 8'h00;
                pend_next[2] = 8'h00;
                pc_next      = 2'd0;
                el_next      = 3'd0;
                stop_next    = 1'b0;
                space_next   = budget_of(cap_reg);
            end
            else if (!stop_reg)
            begin
                space_next = space_reg - {{(CAP_W-RES_CNT_W){1'b0}}, emit_cnt};
                stop_next  = over;
                if (do_flush_old)
                begin
                    pc_next = 2'd0;
                    el_next = 3'd0;
                end
                if (do_fresh && fresh_lead)
                begin
                    pend_next[0] = cur_b;
                    pc_next      = 2'd1;
                    el_next      = fresh_el;
                end
                if (cont_path)
                begin
                    if (complete)
                    begin
                        pc_next = 2'd0;
                        el_next = 3'd0;
                    end
                    else
                    begin
                        case (pc_reg)
                            2'd1:    pend_next[1] = cur_b;
                            2'd2:    pend_next[2] = cur_b;
                            default: ;
                        endcase
                        pc_next = pc_reg + 2'd1;
                    end
                end
            end
        end
        if (cfg_we)
        begin
            cap_next   = cfg_data;
            space_next = budget_of(cfg_data);
        end
    end

    // result buffer control
    assign dst_valid = (buf_rd_reg != buf_cnt_reg);
    assign src_ready = (buf_rd_reg == buf_cnt_reg) ||
                       (((buf_rd_reg + 3'd1) == buf_cnt_reg) && dst_ready);
    assign at_end    = ((buf_rd_reg + 3'd1) == buf_cnt_reg);

    always_comb
    begin
        buf_cnt_next    = buf_cnt_reg;
        buf_rd_next     = buf_rd_reg;
        buf_marker_next = buf_marker_reg;
        buf_last_next   = buf_last_reg;
        buf_trunc_next  = buf_trunc_reg;
        if (accept)
        begin
            buf_cnt_next    = res_cnt;
            buf_rd_next     = '0;
            buf_marker_next = marker;
            buf_last_next   = ends;
            buf_trunc_next  = ends && (stop_reg || over);
        end
        else if (out_fire)
        begin
            buf_rd_next = buf_rd_reg + 3'd1;
        end
    end

    always_comb
    begin
        dst_data.out_byte   = buf_marker_reg ? 8'h00 : buf_byte_reg[buf_rd_reg];
        dst_data.byte_valid = !buf_marker_reg;
        dst_data.out_last   = buf_last_reg && at_end;
        dst_data.truncated  = buf_trunc_reg && at_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_RESET;
            space_reg      <= CAP_RESET - 1'b1;
            pend_reg[0]    <= 8'h00;
            pend_reg[1]    <= 8'h00;
            pend_reg[2]    <= 8'h00;
            pc_reg         <= 2'd0;
            el_reg         <= 3'd0;
            stop_reg       <= 1'b0;
            buf_cnt_reg    <= '0;
            buf_rd_reg     <= '0;
            buf_marker_reg <= 1'b0;
            buf_last_reg   <= 1'b0;
            buf_trunc_reg  <= 1'b0;
        end
        else
        begin
            cap_reg        <= cap_next;
            space_reg      <= space_next;
            pend_reg       <= pend_next;
            pc_reg         <= pc_next;
            el_reg         <= el_next;
            stop_reg       <= stop_next;
            buf_cnt_reg    <= buf_cnt_next;
            buf_rd_reg     <= buf_rd_next;
            buf_marker_reg <= buf_marker_next;
            buf_last_reg   <= buf_last_next;
            buf_trunc_reg  <= buf_trunc_next;
        end
    end

    // result bytes, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < MAX_RES; k++)
                buf_byte_reg[k] <= slot_byte[k];
        end
    end

`ifndef SYNTHESIS
    a_rd_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        buf_rd_reg <= buf_cnt_reg)
        else $error("read pointer past result count");

    a_pend_short: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg != 2'd0) |-> ({1'b0, pc_reg} < el_reg))
        else $error("pending bytes reach announced length");

    a_space_budget: assert property (@(posedge clk) disable iff (!rst_n)
        space_reg <= budget_of(cap_reg))
        else $error("space left above budget");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_data.byte_valid) |-> (dst_data.out_last && buf_cnt_reg == 3'd1))
        else $error("end-only marker not the final beat");
`endif

endmodule
